// ----- design/vxh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxh_pkg
// Shared widths, codes, reset values and the sequencer state type of the
// voxel energy histogram.
// ----------------------------------------------------------------------------
package vxh_pkg;

  localparam int SUM_BITS     = 48;
  localparam int MAX_BINS_DEF = 262144;

  localparam int POS_W      = 24;
  localparam int SIZE_W     = 20;
  localparam int CNT_W      = 8;
  localparam int ENERGY_W   = 32;
  localparam int BIN_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int PROD_W     = SIZE_W + CNT_W;
  localparam int BITCNT_W   = 3;
  localparam int AXIS_W     = 2;

  // Action codes
  localparam logic ACT_DEPOSIT = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOXEL_SIZE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOXEL_SIZE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOXEL_SIZE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_NX      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_NY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_NZ      = 3'd5;

  // Register reset values
  localparam logic [SIZE_W-1:0] RST_VOXEL_SIZE_X = 20'd10000;
  localparam logic [SIZE_W-1:0] RST_VOXEL_SIZE_Y = 20'd10000;
  localparam logic [SIZE_W-1:0] RST_VOXEL_SIZE_Z = 20'd100;
  localparam logic [CNT_W-1:0]  RST_GRID_NX      = 8'd50;
  localparam logic [CNT_W-1:0]  RST_GRID_NY      = 8'd50;
  localparam logic [CNT_W-1:0]  RST_GRID_NZ      = 8'd100;

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_AX_MUL,
    S_AX_CHK,
    S_AX_DIV,
    S_LIN_A,
    S_LIN_B,
    S_BIN_CHK,
    S_ADD,
    S_TOT_A,
    S_TOT_B,
    S_RD_CHK,
    S_RD_OUT,
    S_DONE
  } state_t;

endpackage

// ----- design/vxh_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxh_in_if
// Input channel: one deposit or bin read request per transaction.
// ----------------------------------------------------------------------------
interface vxh_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [vxh_pkg::POS_W-1:0]     pos_x;
  logic signed [vxh_pkg::POS_W-1:0]     pos_y;
  logic signed [vxh_pkg::POS_W-1:0]     pos_z;
  logic        [vxh_pkg::ENERGY_W-1:0]  deposit_energy;
  logic        [vxh_pkg::BIN_W-1:0]     read_bin;

  modport source (
    output valid, action, pos_x, pos_y, pos_z, deposit_energy, read_bin,
    input  ready
  );
  modport sink (
    input  valid, action, pos_x, pos_y, pos_z, deposit_energy, read_bin,
    output ready
  );
endinterface

// ----- design/vxh_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxh_out_if
// Result channel: one bin result per transaction.
// ----------------------------------------------------------------------------
interface vxh_out_if;
  logic                           valid;
  logic                           ready;
  logic                           in_grid;
  logic [vxh_pkg::BIN_W-1:0]      bin_number;
  logic [vxh_pkg::SUM_BITS-1:0]   bin_total;
  logic                           saturated;

  modport source (
    output valid, in_grid, bin_number, bin_total, saturated,
    input  ready
  );
  modport sink (
    input  valid, in_grid, bin_number, bin_total, saturated,
    output ready
  );
endinterface

// ----- design/vxh_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxh_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface vxh_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vxh_pkg::CFG_IDX_W-1:0]    index;
  logic [vxh_pkg::CFG_DATA_W-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- design/voxel_energy_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_energy_histogram
// Accumulates energy deposits into a 3D voxel grid held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
// din carries one request per transaction: a deposit (position, energy) or a
// read of one linear bin. dout returns exactly one result per request. cfg
// writes the voxel sizes and grid counts and is always ready; write it only
// while the block is idle.
// A deposit runs these steps from acceptance until the block is ready again:
// for each axis a step on the shared multiplier, one range check and eight
// restoring-division steps on the shared subtracter, then two multiply steps
// for the linear bin, a check, and a read-modify-write of the bin RAM. A bin
// read runs two multiply steps for the grid size, a check and a RAM read.
// The result register is loaded in the final step, so the result appears in
// the next cycle. A deposit that fails a range check skips to the final step.
// The block holds one request at a time. A waiting result does not block the
// next request; only if a new result is due while the old one is still not
// taken does the sequencer wait in its final step.
// After reset the registers take their defaults and the bin RAM is cleared
// one entry per cycle through all MAX_BINS entries (262144 by default); din
// is not ready meanwhile.
// ----------------------------------------------------------------------------
module voxel_energy_histogram #(
  parameter int MAX_BINS = vxh_pkg::MAX_BINS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  vxh_cfg_if.sink        cfg,
  vxh_in_if.sink         din,
  vxh_out_if.source      dout
);

  localparam int AW     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int PW     = vxh_pkg::PROD_W;
  localparam int NW     = PW + 2;
  localparam int SB     = vxh_pkg::SUM_BITS;
  localparam int SW1    = SB + 1;
  localparam int SZW    = vxh_pkg::SIZE_W;
  localparam int CW     = vxh_pkg::CNT_W;
  localparam int BCW    = vxh_pkg::BITCNT_W;
  localparam int BNW    = vxh_pkg::BIN_W;
  localparam int EW     = vxh_pkg::ENERGY_W;
  localparam int PSW    = vxh_pkg::POS_W;
  localparam logic [PW-1:0]  MAX_BINS_P = PW'(MAX_BINS);
  localparam logic [AW-1:0]  CLR_LAST   = AW'(MAX_BINS - 1);

  vxh_pkg::state_t state, state_next;

  // Configuration registers
  logic [SZW-1:0] voxel_size_x, voxel_size_y, voxel_size_z;
  logic [CW-1:0]  grid_nx, grid_ny, grid_nz;

  // Captured request
  logic                  act;
  logic signed [PSW-1:0] px, py, pz;
  logic [EW-1:0]         energy;
  logic [BNW-1:0]        rbin;

  // Sequencer datapath
  logic [vxh_pkg::AXIS_W-1:0] axis;
  logic [BCW-1:0]             bit_cnt;
  logic [PW:0]                rem;
  logic [CW-1:0]              quo;
  logic [CW-1:0]              idx_x, idx_y, idx_z;
  logic [PW-1:0]              prod;
  logic [AW-1:0]              clr_addr;

  // Pending result and output register
  logic           res_in_grid, res_sat;
  logic [BNW-1:0] res_bin;
  logic [SB-1:0]  res_total;
  logic           out_valid;
  logic           out_in_grid, out_sat;
  logic [BNW-1:0] out_bin;
  logic [SB-1:0]  out_total;

  // Combinational signals
  logic signed [PSW-1:0] cur_pos;
  logic [SZW-1:0]        cur_size;
  logic [CW-1:0]         cur_cnt;
  logic [SZW-1:0]        mul_a;
  logic [CW-1:0]         mul_b;
  logic [CW-1:0]         mul_add;
  logic [PW-1:0]         mul_p;
  logic signed [NW-1:0]  twop, cs_s, num;
  logic                  ax_ok;
  logic [PW-1:0]         dshift;
  logic [NW-1:0]         trial;
  logic                  borrow;
  logic                  bin_ok, rd_ok;
  logic [SW1-1:0]        sum_raw;
  logic [SB-1:0]         sum_sat;
  logic                  load;
  logic                  accept;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [SB-1:0]  ram_wdata, ram_rdata;

  vxh_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg.ready = 1'b1;
  assign din.ready = (state == vxh_pkg::S_IDLE);
  assign accept    = din.valid && din.ready;

  assign dout.valid      = out_valid;
  assign dout.in_grid    = out_in_grid;
  assign dout.bin_number = out_bin;
  assign dout.bin_total  = out_total;
  assign dout.saturated  = out_sat;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_size_x <= vxh_pkg::RST_VOXEL_SIZE_X;
      voxel_size_y <= vxh_pkg::RST_VOXEL_SIZE_Y;
      voxel_size_z <= vxh_pkg::RST_VOXEL_SIZE_Z;
      grid_nx      <= vxh_pkg::RST_GRID_NX;
      grid_ny      <= vxh_pkg::RST_GRID_NY;
      grid_nz      <= vxh_pkg::RST_GRID_NZ;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        vxh_pkg::REG_VOXEL_SIZE_X: voxel_size_x <= cfg.data;
        vxh_pkg::REG_VOXEL_SIZE_Y: voxel_size_y <= cfg.data;
        vxh_pkg::REG_VOXEL_SIZE_Z: voxel_size_z <= cfg.data;
        vxh_pkg::REG_GRID_NX:      grid_nx      <= cfg.data[CW-1:0];
        vxh_pkg::REG_GRID_NY:      grid_ny      <= cfg.data[CW-1:0];
        vxh_pkg::REG_GRID_NZ:      grid_nz      <= cfg.data[CW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ axis selection
  always_comb begin
    case (axis)
      vxh_pkg::AXIS_X: begin
        cur_pos  = px;
        cur_size = voxel_size_x;
        cur_cnt  = grid_nx;
      end
      vxh_pkg::AXIS_Y: begin
        cur_pos  = py;
        cur_size = voxel_size_y;
        cur_cnt  = grid_ny;
      end
      default: begin
        cur_pos  = pz;
        cur_size = voxel_size_z;
        cur_cnt  = grid_nz;
      end
    endcase
  end

  // ----------------------------------------------------- shared multiplier
  always_comb begin
    mul_a   = cur_size;
    mul_b   = cur_cnt;
    mul_add = '0;
    case (state)
      vxh_pkg::S_LIN_A: begin
        mul_a   = SZW'(idx_z);
        mul_b   = grid_ny;
        mul_add = idx_y;
      end
      vxh_pkg::S_LIN_B: begin
        mul_a   = prod[SZW-1:0];
        mul_b   = grid_nx;
        mul_add = idx_x;
      end
      vxh_pkg::S_TOT_A: begin
        mul_a = SZW'(grid_nx);
        mul_b = grid_ny;
      end
      vxh_pkg::S_TOT_B: begin
        mul_a = prod[SZW-1:0];
        mul_b = grid_nz;
      end
      default: ;
    endcase
  end

  assign mul_p = PW'({{CW{1'b0}}, mul_a} * {{SZW{1'b0}}, mul_b});

  // Range check: the voxel index lies in [0, count) exactly when
  // -count*size <= 2*pos < count*size; prod holds count*size here.
  assign twop  = {{(NW-PSW-1){cur_pos[PSW-1]}}, cur_pos, 1'b0};
  assign cs_s  = {2'b00, prod};
  assign num   = twop + cs_s;
  assign ax_ok = !num[NW-1] && (twop < cs_s);

  // Restoring division step, one quotient bit per cycle, most significant
  // first. The quotient is known to be below 256.
  assign dshift = PW'({cur_size, 1'b0}) << bit_cnt;
  assign trial  = {1'b0, rem} - {2'b00, dshift};
  assign borrow = trial[NW-1];

  assign bin_ok = (prod < MAX_BINS_P);
  assign rd_ok  = (PW'(rbin) < prod) && (PW'(rbin) < MAX_BINS_P);

  assign sum_raw = {1'b0, ram_rdata} + SW1'(energy);
  assign sum_sat = sum_raw[SB] ? {SB{1'b1}} : sum_raw[SB-1:0];

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vxh_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = prod[AW-1:0];
    load       = 1'b0;
    case (state)
      vxh_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == CLR_LAST) begin
          state_next = vxh_pkg::S_IDLE;
        end
      end
      vxh_pkg::S_IDLE: begin
        if (din.valid) begin
          state_next = (din.action == vxh_pkg::ACT_READ) ? vxh_pkg::S_TOT_A
                                                         : vxh_pkg::S_AX_MUL;
        end
      end
      vxh_pkg::S_AX_MUL: state_next = vxh_pkg::S_AX_CHK;
      vxh_pkg::S_AX_CHK: state_next = ax_ok ? vxh_pkg::S_AX_DIV : vxh_pkg::S_DONE;
      vxh_pkg::S_AX_DIV: begin
        if (bit_cnt == '0) begin
          state_next = (axis == vxh_pkg::AXIS_Z) ? vxh_pkg::S_LIN_A
                                                 : vxh_pkg::S_AX_MUL;
        end
      end
      vxh_pkg::S_LIN_A: state_next = vxh_pkg::S_LIN_B;
      vxh_pkg::S_LIN_B: state_next = vxh_pkg::S_BIN_CHK;
      vxh_pkg::S_BIN_CHK: begin
        if (bin_ok) begin
          ram_re     = 1'b1;
          state_next = vxh_pkg::S_ADD;
        end else begin
          state_next = vxh_pkg::S_DONE;
        end
      end
      vxh_pkg::S_ADD: begin
        ram_we     = 1'b1;
        ram_waddr  = prod[AW-1:0];
        ram_wdata  = sum_sat;
        state_next = vxh_pkg::S_DONE;
      end
      vxh_pkg::S_TOT_A: state_next = vxh_pkg::S_TOT_B;
      vxh_pkg::S_TOT_B: state_next = vxh_pkg::S_RD_CHK;
      vxh_pkg::S_RD_CHK: begin
        if (rd_ok) begin
          ram_re     = 1'b1;
          ram_raddr  = AW'(rbin);
          state_next = vxh_pkg::S_RD_OUT;
        end else begin
          state_next = vxh_pkg::S_DONE;
        end
      end
      vxh_pkg::S_RD_OUT: state_next = vxh_pkg::S_DONE;
      vxh_pkg::S_DONE: begin
        if (!out_valid || dout.ready) begin
          load       = 1'b1;
          state_next = vxh_pkg::S_IDLE;
        end
      end
      default: state_next = vxh_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------- clearing
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == vxh_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // ------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state)
      vxh_pkg::S_IDLE: begin
        if (accept) begin
          act         <= din.action;
          px          <= din.pos_x;
          py          <= din.pos_y;
          pz          <= din.pos_z;
          energy      <= din.deposit_energy;
          rbin        <= din.read_bin;
          axis        <= vxh_pkg::AXIS_X;
          res_in_grid <= 1'b0;
          res_bin     <= '0;
          res_total   <= '0;
          res_sat     <= 1'b0;
        end
      end
      vxh_pkg::S_AX_MUL: prod <= mul_p;
      vxh_pkg::S_AX_CHK: begin
        rem     <= num[PW:0];
        bit_cnt <= BCW'(CW - 1);
        quo     <= '0;
      end
      vxh_pkg::S_AX_DIV: begin
        if (!borrow) begin
          rem <= trial[PW:0];
        end
        quo     <= {quo[CW-2:0], ~borrow};
        bit_cnt <= bit_cnt - 1'b1;
        if (bit_cnt == '0) begin
          case (axis)
            vxh_pkg::AXIS_X: idx_x <= {quo[CW-2:0], ~borrow};
            vxh_pkg::AXIS_Y: idx_y <= {quo[CW-2:0], ~borrow};
            default:         idx_z <= {quo[CW-2:0], ~borrow};
          endcase
          axis <= axis + 1'b1;
        end
      end
      vxh_pkg::S_LIN_A, vxh_pkg::S_LIN_B,
      vxh_pkg::S_TOT_A, vxh_pkg::S_TOT_B: begin
        prod <= mul_p + PW'(mul_add);
      end
      vxh_pkg::S_ADD: begin
        res_in_grid <= 1'b1;
        res_bin     <= prod[BNW-1:0];
        res_total   <= sum_sat;
        res_sat     <= sum_raw[SB];
      end
      vxh_pkg::S_RD_OUT: begin
        res_in_grid <= 1'b1;
        res_bin     <= rbin;
        res_total   <= ram_rdata;
        res_sat     <= 1'b0;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_in_grid <= res_in_grid;
      out_bin     <= res_bin;
      out_total   <= res_total;
      out_sat     <= res_sat && (act == vxh_pkg::ACT_DEPOSIT);
    end
  end

  // ----------------------------------------------------------- assertions
`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != vxh_pkg::S_IDLE))
    else $error("sequencer still idle after a request transaction");

  a_sat_is_max: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.saturated) |-> (&dout.bin_total))
    else $error("saturated result without a full-scale bin total");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.in_grid) |->
      (dout.bin_number == '0 && dout.bin_total == '0 && !dout.saturated))
    else $error("result outside the grid carries non-zero fields");
`endif

endmodule

// ----- design/vxh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vxh_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module vxh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
